// ===== rtl/ksc_pkg.sv =====
// ============================================================================
// ksc_pkg: shared types and constants for the keyword substitution cipher
// Letter classification record, command codes and alphabet constants.
// ============================================================================
package ksc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = 5;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(LETTERS - 1);
    localparam logic [IDX_W-1:0] LETTERS_IDX = IDX_W'(LETTERS);

    localparam logic [7:0] UPPER_A  = 8'd65;
    localparam logic [7:0] UPPER_Z  = 8'd90;
    localparam logic [7:0] LOWER_A  = 8'd97;
    localparam logic [7:0] CASE_GAP = 8'd32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_KEY    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_TEXT   = 2'd3;

    typedef struct packed {
        logic             is_letter;
        logic             is_lower;
        logic [IDX_W-1:0] idx;
    } letter_t;

endpackage

// ===== rtl/ksc_ram.sv =====
// ============================================================================
// ksc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module ksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ksc_letter.sv =====
// ============================================================================
// ksc_letter: byte classifier
// Flag upper or lower case letters and give the alphabet index.
// ============================================================================
module ksc_letter (
    input  logic [7:0]       data_byte,
    output ksc_pkg::letter_t letter
);

    logic is_upper;
    logic is_lower;
    logic [7:0] base;
    logic [7:0] offset;

    assign is_upper = (data_byte >= ksc_pkg::UPPER_A) && (data_byte <= ksc_pkg::UPPER_Z);
    assign is_lower = (data_byte >= ksc_pkg::LOWER_A) &&
                      (data_byte <= (ksc_pkg::UPPER_Z + ksc_pkg::CASE_GAP));

    assign base   = is_lower ? ksc_pkg::LOWER_A : ksc_pkg::UPPER_A;
    assign offset = data_byte - base;

    always_comb
    begin
        letter.is_letter = is_upper || is_lower;
        letter.is_lower  = is_lower;
        // offset is only meaningful for letters; drop the high bits
        letter.idx       = offset[ksc_pkg::IDX_W-1:0];
    end

endmodule

// ===== rtl/keyword_substitution_cipher.sv =====
// ============================================================================
// keyword_substitution_cipher: keyword substitution cipher engine
// Builds a cipher alphabet from key letters and substitutes text bytes.
// ============================================================================
//
// Usage:
//   Input words arrive on s_axis: tuser carries the command (clear, key byte,
//   finish, text byte), tdata the raw byte. Results leave on m_axis, one word
//   per text byte only; other commands give no result.
//   cfg_we/cfg_wdata set the mode (0 encrypt through the forward table,
//   1 decrypt through the inverse table); write it only while idle.
// Sequences:
//   Clear and key byte: the next word may follow at once.
//   Text byte: table RAM read, then output register load, which waits
//   until m_axis is free.
//   Finish: after the accepting cycle, a walk from Z down to A through the
//   one letter write port, then a stream of the forward RAM into the inverse RAM.
//   s_axis_tready is low while any of these sequences runs.
// Reset:
//   Both tables read as identity (per-entry valid bits cleared), no letters
//   used, mode encrypt. No clearing pass is needed.
// Stall:
//   A pending result holds in the output register; the block still accepts
//   words, and the next text byte waits in its lookup step.
//
module keyword_substitution_cipher (
    input  logic       clk,
    input  logic       rst_n,
    // s_axis
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] cmd
    // m_axis
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    localparam int IW = ksc_pkg::IDX_W;
    localparam int NL = ksc_pkg::LETTERS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_INV  = 2'd2;
    localparam logic [1:0] ST_LOOK = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] fill_reg, fill_next;
    logic [NL-1:0] used_reg, used_next;
    logic [NL-1:0] fwd_vld_reg, fwd_vld_next;
    logic [NL-1:0] inv_vld_reg, inv_vld_next;
    logic          mode_reg;
    logic          ent_vld_reg, ent_vld_next;    // valid bit of entry being read
    ksc_pkg::letter_t hold_let_reg;
    logic [7:0]    hold_byte_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;

    ksc_pkg::letter_t in_let;
    logic          in_fire;
    logic          text_fire;
    logic          key_place;
    logic          fill_place;
    logic          cnt_in_range;
    logic          ld_out;

    logic          fwd_we;
    logic [IW-1:0] fwd_wdata;
    logic          fwd_re;
    logic [IW-1:0] fwd_raddr;
    logic [IW-1:0] fwd_rdata;
    logic          inv_we;
    logic [IW-1:0] inv_waddr;
    logic [IW-1:0] inv_wdata;
    logic          inv_re;
    logic [IW-1:0] inv_rdata;
    logic [IW-1:0] prev_cnt;
    logic [IW-1:0] look_idx;
    logic [7:0]    look_base;
    logic [7:0]    result;

    ksc_letter u_letter (
        .data_byte (s_axis_tdata),
        .letter    (in_let)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign text_fire     = in_fire && (s_axis_tuser == ksc_pkg::CMD_TEXT);
    assign cnt_in_range  = (cnt_reg < ksc_pkg::LETTERS_IDX);
    assign prev_cnt      = cnt_reg - IW'(1);

    // Place a key letter when new and the alphabet is not yet full
    assign key_place = in_fire && (s_axis_tuser == ksc_pkg::CMD_KEY) && in_let.is_letter
                       && !used_reg[in_let.idx] && (fill_reg < ksc_pkg::LETTERS_IDX);
    // Fill walk: append each unused letter from Z down to A
    assign fill_place = (state_reg == ST_FILL) && !used_reg[cnt_reg]
                        && (fill_reg < ksc_pkg::LETTERS_IDX);

    assign fwd_we    = key_place || fill_place;
    assign fwd_wdata = key_place ? in_let.idx : cnt_reg;

    // Forward RAM read: inverse build walk, or encrypt lookup
    assign fwd_re    = ((state_reg == ST_INV) && cnt_in_range) || (text_fire && !mode_reg);
    assign fwd_raddr = (state_reg == ST_INV) ? cnt_reg : in_let.idx;
    assign inv_re    = text_fire && mode_reg;

    // Inverse build writes in the cycle after each forward read
    assign inv_we    = (state_reg == ST_INV) && (cnt_reg != '0);
    assign inv_waddr = ent_vld_reg ? fwd_rdata : prev_cnt;
    assign inv_wdata = prev_cnt;

    ksc_ram #(
        .WIDTH (IW),
        .DEPTH (NL)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fill_reg),
        .wdata (fwd_wdata),
        .re    (fwd_re),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    ksc_ram #(
        .WIDTH (IW),
        .DEPTH (NL)
    ) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .re    (inv_re),
        .raddr (in_let.idx),
        .rdata (inv_rdata)
    );

    // Lookup result: an entry never written reads as identity
    assign look_idx  = ent_vld_reg ? (mode_reg ? inv_rdata : fwd_rdata) : hold_let_reg.idx;
    assign look_base = hold_let_reg.is_lower ? ksc_pkg::LOWER_A : ksc_pkg::UPPER_A;
    assign result    = hold_let_reg.is_letter ? (look_base + {{(8 - IW){1'b0}}, look_idx})
                                              : hold_byte_reg;

    assign ld_out = (state_reg == ST_LOOK) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        used_next      = used_reg;
        fwd_vld_next   = fwd_vld_reg;
        inv_vld_next   = inv_vld_reg;
        ent_vld_next   = ent_vld_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (fwd_we)
        begin
            fwd_vld_next[fill_reg] = 1'b1;
            used_next[fwd_wdata]   = 1'b1;
            fill_next              = fill_reg + IW'(1);
        end

        if (inv_we)
        begin
            inv_vld_next[inv_waddr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        ksc_pkg::CMD_CLEAR:
                        begin
                            used_next    = '0;
                            fwd_vld_next = '0;
                            inv_vld_next = '0;
                            fill_next    = '0;
                        end
                        ksc_pkg::CMD_KEY:
                        begin
                            // handled by the shared letter write port
                        end
                        ksc_pkg::CMD_FINISH:
                        begin
                            cnt_next   = ksc_pkg::LAST_IDX;
                            state_next = ST_FILL;
                        end
                        ksc_pkg::CMD_TEXT:
                        begin
                            ent_vld_next = mode_reg ? inv_vld_reg[in_let.idx]
                                                    : fwd_vld_reg[in_let.idx];
                            state_next   = ST_LOOK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_INV;
                end
                else
                begin
                    cnt_next = cnt_reg - IW'(1);
                end
            end
            ST_INV:
            begin
                // capture valid bit of the forward entry read this cycle
                ent_vld_next = cnt_in_range ? fwd_vld_reg[cnt_reg] : 1'b0;
                if (cnt_reg == ksc_pkg::LETTERS_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_LOOK:
            begin
                if (ld_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            used_reg      <= '0;
            fwd_vld_reg   <= '0;
            inv_vld_reg   <= '0;
            ent_vld_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            used_reg      <= used_next;
            fwd_vld_reg   <= fwd_vld_next;
            inv_vld_reg   <= inv_vld_next;
            ent_vld_reg   <= ent_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (text_fire)
        begin
            hold_let_reg  <= in_let;
            hold_byte_reg <= s_axis_tdata;
        end
        if (ld_out)
        begin
            out_byte_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ksc_pkg::LETTERS_IDX)
        else $error("fill count beyond alphabet size");

    a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) && (cnt_reg == '0) |=>
            (&used_reg) && (fill_reg == ksc_pkg::LETTERS_IDX))
        else $error("alphabet not complete after fill walk");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ld_out |-> (!out_valid_reg || m_axis_tready))
        else $error("pending result overwritten");

    a_look_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |->
            ($past(state_reg) == ST_IDLE) || ($past(state_reg) == ST_LOOK))
        else $error("lookup entered from table build");

    a_inv_only_build: assert property (@(posedge clk) disable iff (!rst_n)
        inv_we |-> !fwd_we && !in_fire)
        else $error("inverse write outside table build");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the keyword substitution cipher
// Streams clear, key, finish and text words into the block, mirrors the
// alphabet tables in a local predictor and checks every substituted byte,
// under several flow-control patterns and in both encrypt and decrypt mode.
// ============================================================================
module testbench;

    import ksc_pkg::*;

    // One input word: command in tuser, raw byte in tdata
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } cipher_word_t;

    // Cycles to let pass after the last result before a mode write or the end:
    // a finish walk gives no result of its own.
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_WORDS   = 100;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;     // [7:0] data_byte
    logic [1:0] s_axis_tuser = 2'd0;     // [1:0] cmd
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;

    // Words waiting for the driver, and substituted bytes waiting for the block
    cipher_word_t pending_words[$];
    logic [7:0]   expected_text[$];

    // Local copy of the cipher state
    logic [IDX_W-1:0] fwd_alpha [LETTERS];
    logic [IDX_W-1:0] inv_alpha [LETTERS];
    logic [LETTERS-1:0] used_mask;
    int unsigned      fill_pos;
    logic             cipher_mode;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned key_builds = 0;
    logic        word_taken = 1'b0;
    cipher_word_t next_word;

    always #2 clk = ~clk;

    keyword_substitution_cipher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic letter_t classify_byte(input logic [7:0] ch);
        letter_t lt;
        lt = '0;
        if (ch >= UPPER_A && ch <= UPPER_Z)
        begin
            lt.is_letter = 1'b1;
            lt.idx = IDX_W'(ch - UPPER_A);
        end
        else if (ch >= LOWER_A && ch <= UPPER_Z + CASE_GAP)
        begin
            lt.is_letter = 1'b1;
            lt.is_lower = 1'b1;
            lt.idx = IDX_W'(ch - LOWER_A);
        end
        return lt;
    endfunction

    task automatic reset_alphabet();
        for (int i = 0; i < LETTERS; i++)
        begin
            fwd_alpha[i] = IDX_W'(i);
            inv_alpha[i] = IDX_W'(i);
        end
        used_mask = '0;
        fill_pos = 0;
    endtask

    // Append a letter to the cipher alphabet unless already placed or full
    task automatic append_letter(input logic [IDX_W-1:0] idx);
        if (!used_mask[idx] && fill_pos < LETTERS)
        begin
            fwd_alpha[fill_pos] = idx;
            used_mask[idx] = 1'b1;
            fill_pos++;
        end
    endtask

    // Advance the local state by one accepted word; queue the byte it yields
    task automatic cipher_accept(input logic [1:0] cmd, input logic [7:0] ch);
        letter_t lt;
        logic [IDX_W-1:0] sub;
        lt = classify_byte(ch);
        case (cmd)
            CMD_CLEAR:
                reset_alphabet();
            CMD_KEY:
                if (lt.is_letter)
                    append_letter(lt.idx);
            CMD_FINISH:
            begin
                // Fill the rest from Z down to A, then rebuild the inverse
                for (int k = LETTERS - 1; k >= 0; k--)
                    append_letter(IDX_W'(k));
                for (int i = 0; i < LETTERS; i++)
                    inv_alpha[fwd_alpha[i] % LETTERS] = IDX_W'(i);
                key_builds++;
            end
            default:
            begin
                if (!lt.is_letter)
                    expected_text.push_back(ch);
                else
                begin
                    sub = cipher_mode ? inv_alpha[lt.idx] : fwd_alpha[lt.idx];
                    expected_text.push_back((lt.is_lower ? LOWER_A : UPPER_A) + 8'(sub));
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present words at the falling edge, hold until accepted
    // ------------------------------------------------------------------------

    // Acceptance at the rising edge: update the predictor in acceptance order
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            cipher_accept(s_axis_tuser, s_axis_tdata);
            words_sent++;
            word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || word_taken))
        begin
            // Idle at random per the current phase, otherwise load the next word
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_word.cmd;
                s_axis_tdata  <= next_word.data;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        word_taken = 1'b0;
        // Stall the result side at random per the current phase
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result word against the oldest expected byte
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_text.size() == 0)
                report_mismatch($sformatf("unexpected result word 0x%02h", m_axis_tdata));
            else
            begin
                if (m_axis_tdata !== expected_text[0])
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              m_axis_tdata, expected_text[0]));
                void'(expected_text.pop_front());
                bytes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic push_word(input logic [1:0] cmd, input logic [7:0] data);
        cipher_word_t w;
        w.cmd = cmd;
        w.data = data;
        pending_words.push_back(w);
    endtask

    // Mostly letters of either case, sometimes any byte at all
    function automatic logic [7:0] pick_byte(input int unsigned letter_pct);
        if ($urandom_range(99) < letter_pct)
            return ($urandom_range(1) ? LOWER_A : UPPER_A) + 8'($urandom_range(LETTERS - 1));
        return 8'($urandom_range(255));
    endfunction

    // Wait until every word is taken and every result is back, then settle
    task automatic drain();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_text.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the mode register; only called while the block is idle
    task automatic write_mode(input logic value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cipher_mode = value;
    endtask

    // Random traffic: mostly whole key sessions, some partial keys and noise
    task automatic random_phase(input int unsigned n_words);
        int unsigned queued;
        int unsigned kind;
        int unsigned n_key;
        queued = 0;
        while (queued < n_words)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                // Whole session; now and then keep the previous key marks
                if ($urandom_range(9) != 0)
                begin
                    push_word(CMD_CLEAR, 8'($urandom_range(255)));
                    queued++;
                end
                n_key = ($urandom_range(9) == 0) ? 30 : $urandom_range(12);
                for (int i = 0; i < n_key; i++)
                    push_word(CMD_KEY, pick_byte(75));
                queued += n_key;
                push_word(CMD_FINISH, 8'($urandom_range(255)));
                n_key = $urandom_range(4, 20);
                for (int i = 0; i < n_key; i++)
                    push_word(CMD_TEXT, pick_byte(75));
                queued = queued + 1 + n_key;
            end
            else if (kind < 80)
            begin
                // Text while the key is only partly entered
                n_key = $urandom_range(1, 6);
                for (int i = 0; i < n_key; i++)
                    push_word(CMD_KEY, pick_byte(80));
                for (int i = 0; i < 6; i++)
                    push_word(CMD_TEXT, pick_byte(70));
                queued = queued + n_key + 6;
            end
            else
            begin
                // Noise: any command, any byte
                n_key = $urandom_range(3, 8);
                for (int i = 0; i < n_key; i++)
                    push_word(2'($urandom_range(3)), 8'($urandom_range(255)));
                queued += n_key;
            end
        end
    endtask

    initial
    begin
        reset_alphabet();
        cipher_mode = 1'b0;

        // Hold reset, then release away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(1'b0);

        // Directed: identity tables and the letter range boundaries
        push_word(CMD_TEXT, UPPER_A);
        push_word(CMD_TEXT, UPPER_Z);
        push_word(CMD_TEXT, LOWER_A);
        push_word(CMD_TEXT, UPPER_Z + CASE_GAP);
        push_word(CMD_TEXT, UPPER_A - 8'd1);
        push_word(CMD_TEXT, UPPER_Z + 8'd1);
        push_word(CMD_TEXT, LOWER_A - 8'd1);
        push_word(CMD_TEXT, UPPER_Z + CASE_GAP + 8'd1);
        push_word(CMD_TEXT, 8'h00);
        push_word(CMD_TEXT, 8'hFF);
        // Key with a folded repeat and a non-letter byte
        push_word(CMD_CLEAR, 8'hFF);
        push_word(CMD_KEY, "K");
        push_word(CMD_KEY, "e");
        push_word(CMD_KEY, "y");
        push_word(CMD_KEY, "k");
        push_word(CMD_KEY, "1");
        push_word(CMD_KEY, "W");
        push_word(CMD_FINISH, 8'h00);
        // Key byte after finish, then a second finish
        push_word(CMD_KEY, "Q");
        push_word(CMD_FINISH, 8'hFF);
        push_word(CMD_TEXT, "K");
        push_word(CMD_TEXT, "e");
        push_word(CMD_TEXT, "z");
        push_word(CMD_TEXT, "Z");
        push_word(CMD_TEXT, "!");
        drain();

        // Random phases: free flow, idle sender, stalling receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            write_mode(phase[0]);
            random_phase(PHASE_WORDS);
            drain();
        end

        $display("Sent %0d words, checked %0d substituted bytes, %0d key builds,",
                 words_sent, bytes_checked, key_builds);
        $display("in encrypt and decrypt mode under four flow-control patterns.");
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_text.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
